### rtl/bounded_ring_deque_top_assert.svh
// Assertion macros for the deque RTL, included by the index logic (brd_ctrl).
// Both sample on the rising edge of clk and report through $error.
`ifndef BOUNDED_RING_DEQUE_TOP_ASSERT_SVH
`define BOUNDED_RING_DEQUE_TOP_ASSERT_SVH

// Check that holds at every edge once reset is released
`define BRD_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("deque check failed");

// Check that must hold in the cycle after a trigger
`define BRD_ASSERT_NEXT(name, trig, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error("deque check failed");

`endif

### rtl/brd_pkg.sv
package brd_pkg;

  // fixed field widths
  localparam int OP_W    = 3;
  localparam int SIZE_W  = 5;
  localparam int COUNT_W = 5;

  // size register value after reset
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // operation codes; codes above the last member act as none
  typedef enum logic [OP_W-1:0] {
    OP_NONE      = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_INS_BACK  = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4
  } op_t;

  // control from the index logic to the store
  typedef struct packed {
    logic accept;   // a word is taken this cycle
    logic wr_en;    // the word's value goes into the store
    logic empty;    // the deque is empty after this word
  } store_ctl_t;

endpackage

### rtl/bounded_ring_deque_top.sv
// Channel | Direction | Handshake         | Payload
// input   | in        | in_valid/in_stall | in_operation, in_value
// result  | out       | out_valid/out_stall | accepted, front/rear value, count, flags
// config  | in        | cfg_we            | cfg_wdata (size in use)
//
// One word in, one result out; a word is taken every cycle while results drain.
// The result appears in the cycle after its word is taken, from the result registers and
// the registered store reads at the new front and rear indices.
// Reset is synchronous, active low: empty deque, size in use 16; store not cleared.
// in_stall is raised only while a result waits and out_stall holds it.
module bounded_ring_deque_top #(
  parameter int DEPTH = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [brd_pkg::OP_W-1:0]    in_operation,
  input  logic signed [WORD_BITS-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_accepted,
  output logic signed [WORD_BITS-1:0] out_front_value,
  output logic signed [WORD_BITS-1:0] out_rear_value,
  output logic [brd_pkg::COUNT_W-1:0] out_entry_count,
  output logic                        out_is_empty,
  output logic                        out_is_full,
  input  logic                        cfg_we,
  input  logic [brd_pkg::SIZE_W-1:0]  cfg_wdata
);
  import brd_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic               accept;
  logic [IDX_W-1:0]   head_nxt;
  logic [IDX_W-1:0]   tail_nxt;
  logic [IDX_W-1:0]   waddr;
  store_ctl_t         ctl;
  logic               op_ok;
  logic [COUNT_W-1:0] count_nxt;
  logic               full_nxt;

  logic               out_valid_r;
  logic               accepted_r;
  logic [COUNT_W-1:0] count_r;
  logic               empty_r;
  logic               full_r;

  // a word is taken unless a finished result is held back
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  brd_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .operation (in_operation),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head_nxt  (head_nxt),
    .tail_nxt  (tail_nxt),
    .waddr     (waddr),
    .ctl       (ctl),
    .op_ok     (op_ok),
    .count_nxt (count_nxt),
    .full_nxt  (full_nxt)
  );

  brd_store #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_store (
    .clk         (clk),
    .ctl         (ctl),
    .waddr       (waddr),
    .wdata       (in_value),
    .front_addr  (head_nxt),
    .rear_addr   (tail_nxt),
    .front_value (out_front_value),
    .rear_value  (out_rear_value)
  );

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      accepted_r <= op_ok;
      count_r    <= count_nxt;
      empty_r    <= ctl.empty;
      full_r     <= full_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = accepted_r;
  assign out_entry_count = count_r;
  assign out_is_empty    = empty_r;
  assign out_is_full     = full_r;

endmodule

### rtl/brd_ctrl.sv
module brd_ctrl #(
  parameter int DEPTH = 16,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [brd_pkg::OP_W-1:0]    operation,
  input  logic                        cfg_we,
  input  logic [brd_pkg::SIZE_W-1:0]  cfg_wdata,
  output logic [IDX_W-1:0]            head_nxt,
  output logic [IDX_W-1:0]            tail_nxt,
  output logic [IDX_W-1:0]            waddr,
  output brd_pkg::store_ctl_t         ctl,
  output logic                        op_ok,
  output logic [brd_pkg::COUNT_W-1:0] count_nxt,
  output logic                        full_nxt
);
  import brd_pkg::*;

  // arithmetic width: holds any index plus one and any size
  localparam int AW = ((IDX_W >= SIZE_W) ? IDX_W : SIZE_W) + 1;

  logic [SIZE_W-1:0]  size_r;
  logic [IDX_W-1:0]   head_r;
  logic [IDX_W-1:0]   tail_r;
  logic [COUNT_W-1:0] count_r;

  logic [SIZE_W-1:0]  cap;
  logic [AW-1:0]      cap_w;
  logic [AW-1:0]      head_w;
  logic [AW-1:0]      tail_w;
  logic [AW-1:0]      head_sum;
  logic [AW-1:0]      tail_sum;
  logic               ins_front;
  logic               wr_raw;

  // effective size: zero acts as one, clipped to the depth
  always_comb begin
    cap = (size_r == '0) ? SIZE_W'(1) : size_r;
    if (32'(cap) > 32'(DEPTH)) begin
      cap = SIZE_W'(DEPTH);
    end
  end

  assign cap_w  = AW'(cap);
  assign head_w = AW'(head_r);
  assign tail_w = AW'(tail_r);

  // next indices and count for the requested operation
  always_comb begin
    head_sum  = head_w;
    tail_sum  = tail_w;
    count_nxt = count_r;
    op_ok     = 1'b0;
    wr_raw    = 1'b0;
    ins_front = 1'b0;
    case (op_t'(operation))
      OP_INS_FRONT, OP_INS_BACK: begin
        if (count_r < cap) begin
          op_ok     = 1'b1;
          wr_raw    = 1'b1;
          count_nxt = count_r + COUNT_W'(1);
          if (count_r == '0) begin
            head_sum = '0;
            tail_sum = '0;
          end else if (op_t'(operation) == OP_INS_FRONT) begin
            ins_front = 1'b1;
            head_sum  = (head_w == '0) ? cap_w - AW'(1) : head_w - AW'(1);
          end else begin
            tail_sum = (tail_w + AW'(1) >= cap_w) ? '0 : tail_w + AW'(1);
          end
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK: begin
        if (count_r != '0) begin
          op_ok     = 1'b1;
          count_nxt = count_r - COUNT_W'(1);
          if (count_r == COUNT_W'(1)) begin
            head_sum = '0;
            tail_sum = '0;
          end else if (op_t'(operation) == OP_DEL_FRONT) begin
            head_sum = (head_w + AW'(1) >= cap_w) ? '0 : head_w + AW'(1);
          end else begin
            tail_sum = (tail_w == '0) ? cap_w - AW'(1) : tail_w - AW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign head_nxt  = head_sum[IDX_W-1:0];
  assign tail_nxt  = tail_sum[IDX_W-1:0];
  // insert into empty lands at zero, where both indices point
  assign waddr     = ins_front ? head_nxt : tail_nxt;
  assign full_nxt  = (count_nxt == COUNT_W'(cap));
  assign ctl.accept = accept;
  assign ctl.wr_en  = accept & wr_raw;
  assign ctl.empty  = (count_nxt == '0);

  // index, count and size registers; a size write empties the deque
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= SIZE_RESET;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (cfg_we) begin
      size_r  <= cfg_wdata;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

`include "bounded_ring_deque_top_assert.svh"

  `BRD_ASSERT(a_count_within_cap, count_r <= COUNT_W'(cap))
  `BRD_ASSERT(a_empty_indices_zero, (count_r != '0) || (head_r == '0 && tail_r == '0))
  `BRD_ASSERT(a_indices_within_cap, (AW'(head_r) < cap_w) && (AW'(tail_r) < cap_w))
  `BRD_ASSERT_NEXT(a_cfg_clears, cfg_we, count_r == '0)

endmodule

### rtl/brd_store.sv
module brd_store #(
  parameter int DEPTH = 16,
  parameter int WORD_BITS = 32,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  brd_pkg::store_ctl_t         ctl,
  input  logic [IDX_W-1:0]            waddr,
  input  logic signed [WORD_BITS-1:0] wdata,
  input  logic [IDX_W-1:0]            front_addr,
  input  logic [IDX_W-1:0]            rear_addr,
  output logic signed [WORD_BITS-1:0] front_value,
  output logic signed [WORD_BITS-1:0] rear_value
);
  import brd_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] front_r;
  logic [WORD_BITS-1:0] rear_r;

  // ring store write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // registered reads at the new front and rear, write-first on a match;
  // all ones when the deque is empty
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      if (ctl.empty) begin
        front_r <= '1;
        rear_r  <= '1;
      end else begin
        front_r <= (ctl.wr_en && front_addr == waddr) ? wdata : mem[front_addr];
        rear_r  <= (ctl.wr_en && rear_addr == waddr) ? wdata : mem[rear_addr];
      end
    end
  end

  assign front_value = front_r;
  assign rear_value  = rear_r;

endmodule

### tb/bounded_ring_deque_top_tb.sv
`timescale 1ns / 100ps

module bounded_ring_deque_top_tb;
  import brd_pkg::*;

  localparam int DEPTH = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SETTLE_CYCLES = 4;
  localparam int WORDS_PER_SIZE = 50;
  localparam int HOLD_CYCLES = 80;
  // codes above the last operation act as none
  localparam logic [OP_W-1:0] OP_CODE_UNUSED = 3'd7;
  // front/rear readback of an empty deque
  localparam logic [WORD_BITS-1:0] NO_WORD = '1;

  typedef struct packed {
    logic                 accepted;
    logic [WORD_BITS-1:0] front_value;
    logic [WORD_BITS-1:0] rear_value;
    logic [COUNT_W-1:0]   entry_count;
    logic                 is_empty;
    logic                 is_full;
  } deque_view_t;

  typedef struct packed {
    logic        known;
    deque_view_t view;
  } typed_view_t;

  typedef enum logic {ROW_WORD, ROW_SIZE} row_kind_t;
  typedef enum int {LEAN_FILL, LEAN_DRAIN, LEAN_MIXED} lean_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [OP_W-1:0]      op;
    logic [WORD_BITS-1:0] value;
    logic                 known;
    deque_view_t          view;
  } stim_row_t;

  localparam int NUM_ROWS = 27;

  // directed part: empty-deque refusals, extremes, size rewrites and wrap
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_WORD, OP_DEL_FRONT, 32'h0, 1'b1, '{1'b0, NO_WORD, NO_WORD, 5'd0, 1'b1, 1'b0}},
    '{ROW_WORD, OP_DEL_BACK, 32'h0, 1'b1, '{1'b0, NO_WORD, NO_WORD, 5'd0, 1'b1, 1'b0}},
    '{ROW_WORD, OP_NONE, 32'h1234_5678, 1'b1, '{1'b0, NO_WORD, NO_WORD, 5'd0, 1'b1, 1'b0}},
    '{ROW_WORD, OP_CODE_UNUSED, 32'hFFFF_FFFF, 1'b1,
      '{1'b0, NO_WORD, NO_WORD, 5'd0, 1'b1, 1'b0}},
    '{ROW_WORD, OP_INS_BACK, 32'h7FFF_FFFF, 1'b1,
      '{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1, 1'b0, 1'b0}},
    '{ROW_WORD, OP_INS_FRONT, 32'h8000_0000, 1'b1,
      '{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 5'd2, 1'b0, 1'b0}},
    '{ROW_WORD, OP_INS_BACK, 32'h0, 1'b0, '0},
    '{ROW_WORD, OP_INS_FRONT, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_WORD, OP_DEL_FRONT, 32'h0, 1'b0, '0},
    '{ROW_WORD, OP_DEL_BACK, 32'h0, 1'b0, '0},
    '{ROW_WORD, OP_DEL_BACK, 32'h0, 1'b0, '0},
    // last word leaves
    '{ROW_WORD, OP_DEL_FRONT, 32'h0, 1'b1, '{1'b1, NO_WORD, NO_WORD, 5'd0, 1'b1, 1'b0}},
    '{ROW_SIZE, OP_NONE, 32'd1, 1'b0, '0},
    '{ROW_WORD, OP_INS_FRONT, 32'h5A5A_5A5A, 1'b1,
      '{1'b1, 32'h5A5A_5A5A, 32'h5A5A_5A5A, 5'd1, 1'b0, 1'b1}},
    // insert into full is refused
    '{ROW_WORD, OP_INS_BACK, 32'h0000_0001, 1'b1,
      '{1'b0, 32'h5A5A_5A5A, 32'h5A5A_5A5A, 5'd1, 1'b0, 1'b1}},
    '{ROW_WORD, OP_DEL_BACK, 32'h0, 1'b1, '{1'b1, NO_WORD, NO_WORD, 5'd0, 1'b1, 1'b0}},
    // size zero behaves as one
    '{ROW_SIZE, OP_NONE, 32'd0, 1'b0, '0},
    '{ROW_WORD, OP_INS_BACK, 32'hA5A5_A5A5, 1'b0, '0},
    '{ROW_WORD, OP_INS_FRONT, 32'h0000_0001, 1'b0, '0},
    // size above depth behaves as depth
    '{ROW_SIZE, OP_NONE, 32'd31, 1'b0, '0},
    '{ROW_WORD, OP_INS_FRONT, 32'h0000_0002, 1'b0, '0},
    '{ROW_WORD, OP_INS_BACK, 32'h0000_0003, 1'b0, '0},
    // rewrite while holding words empties the deque
    '{ROW_SIZE, OP_NONE, 32'd2, 1'b0, '0},
    '{ROW_WORD, OP_DEL_FRONT, 32'h0, 1'b1, '{1'b0, NO_WORD, NO_WORD, 5'd0, 1'b1, 1'b0}},
    '{ROW_WORD, OP_INS_FRONT, 32'h0000_0004, 1'b0, '0},
    '{ROW_WORD, OP_INS_FRONT, 32'h0000_0005, 1'b0, '0},
    '{ROW_WORD, OP_INS_BACK, 32'h0000_0006, 1'b0, '0}
  };

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [OP_W-1:0]             in_operation = OP_NONE;
  logic signed [WORD_BITS-1:0] in_value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        out_accepted;
  logic signed [WORD_BITS-1:0] out_front_value;
  logic signed [WORD_BITS-1:0] out_rear_value;
  logic [COUNT_W-1:0]          out_entry_count;
  logic                        out_is_empty;
  logic                        out_is_full;
  logic                        cfg_we = 1'b0;
  logic [SIZE_W-1:0]           cfg_wdata = '0;

  // shadow copy of the deque
  logic [WORD_BITS-1:0] shadow_ring [DEPTH];
  int unsigned          shadow_head = 0;
  int unsigned          shadow_tail = 0;
  int unsigned          shadow_count = 0;
  logic [SIZE_W-1:0]    shadow_size = SIZE_RESET;

  deque_view_t expected_views [$];
  typed_view_t typed_views [$];
  int          mismatch_count = 0;
  int          sender_idle_pct = 0;
  int          receiver_idle_pct = 0;
  int          hold_requests = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  bounded_ring_deque_top #(
    .DEPTH(DEPTH),
    .WORD_BITS(WORD_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_accepted(out_accepted),
    .out_front_value(out_front_value),
    .out_rear_value(out_rear_value),
    .out_entry_count(out_entry_count),
    .out_is_empty(out_is_empty),
    .out_is_full(out_is_full),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, field, got, want);
    mismatch_count++;
  endtask

  task automatic check_view(deque_view_t got, deque_view_t want);
    if (got.accepted !== want.accepted)
      report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
    if (got.front_value !== want.front_value)
      report_mismatch("front_value", got.front_value, want.front_value);
    if (got.rear_value !== want.rear_value)
      report_mismatch("rear_value", got.rear_value, want.rear_value);
    if (got.entry_count !== want.entry_count)
      report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
    if (got.is_empty !== want.is_empty)
      report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
    if (got.is_full !== want.is_full)
      report_mismatch("is_full", 32'(got.is_full), 32'(want.is_full));
  endtask

  // deque update for one word, returns the view after it
  function automatic deque_view_t apply_operation(logic [OP_W-1:0] op,
                                                  logic [WORD_BITS-1:0] word);
    deque_view_t view;
    int unsigned cap;
    logic ok;
    cap = (shadow_size == 0) ? 1 : ((shadow_size > DEPTH) ? DEPTH : shadow_size);
    ok = 1'b0;
    case (op)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (shadow_count < cap) begin
          if (shadow_count == 0) begin
            shadow_head = 0;
            shadow_tail = 0;
            shadow_ring[IDX_W'(0)] = word;
          end else if (op == OP_INS_FRONT) begin
            shadow_head = (shadow_head == 0) ? cap - 1 : shadow_head - 1;
            shadow_ring[IDX_W'(shadow_head)] = word;
          end else begin
            shadow_tail = (shadow_tail + 1 >= cap) ? 0 : shadow_tail + 1;
            shadow_ring[IDX_W'(shadow_tail)] = word;
          end
          shadow_count++;
          ok = 1'b1;
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK: begin
        if (shadow_count != 0) begin
          if (shadow_count == 1) begin
            shadow_head = 0;
            shadow_tail = 0;
          end else if (op == OP_DEL_FRONT) begin
            shadow_head = (shadow_head + 1 >= cap) ? 0 : shadow_head + 1;
          end else begin
            shadow_tail = (shadow_tail == 0) ? cap - 1 : shadow_tail - 1;
          end
          shadow_count--;
          ok = 1'b1;
        end
      end
      default: ;
    endcase
    view.accepted = ok;
    view.front_value = (shadow_count == 0) ? NO_WORD : shadow_ring[IDX_W'(shadow_head)];
    view.rear_value = (shadow_count == 0) ? NO_WORD : shadow_ring[IDX_W'(shadow_tail)];
    view.entry_count = COUNT_W'(shadow_count);
    view.is_empty = (shadow_count == 0);
    view.is_full = (shadow_count == cap);
    return view;
  endfunction

  function automatic logic [OP_W-1:0] pick_op(lean_t lean);
    int roll;
    int ins_limit;
    roll = $urandom_range(99);
    if (roll < 6)
      return (roll < 3) ? OP_NONE : OP_W'($urandom_range(5, 7));
    ins_limit = (lean == LEAN_FILL) ? 84 : ((lean == LEAN_DRAIN) ? 20 : 53);
    if (roll < ins_limit)
      return $urandom_range(1) ? OP_INS_FRONT : OP_INS_BACK;
    return $urandom_range(1) ? OP_DEL_FRONT : OP_DEL_BACK;
  endfunction

  function automatic logic [WORD_BITS-1:0] pick_word();
    case ($urandom_range(15))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return NO_WORD;
      default: return $urandom;
    endcase
  endfunction

  // offer one word, hold it until the handshake takes it
  task automatic send_word(logic [OP_W-1:0] op, logic [WORD_BITS-1:0] word,
                           logic known, deque_view_t view);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    typed_views.push_back('{known, view});
    in_valid <= 1'b1;
    in_operation <= op;
    in_value <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // rewrite the size only once every pending result has drained
  task automatic write_size(logic [SIZE_W-1:0] size_value);
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_views.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= size_value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: random stall plus a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // monitor: track config, predict accepted words, check results
  always @(posedge clk) begin
    deque_view_t got;
    deque_view_t predicted;
    typed_view_t typed;
    if (rst_n) begin
      if (cfg_we) begin
        shadow_size = cfg_wdata;
        shadow_head = 0;
        shadow_tail = 0;
        shadow_count = 0;
      end
      if (out_valid && !out_stall) begin
        got = '{out_accepted, out_front_value, out_rear_value, out_entry_count,
                out_is_empty, out_is_full};
        if (expected_views.size() == 0)
          report_mismatch("result with none pending", got.front_value, '0);
        else
          check_view(got, expected_views.pop_front());
      end
      if (in_valid && !in_stall) begin
        predicted = apply_operation(in_operation, in_value);
        typed = typed_views.pop_front();
        expected_views.push_back(typed.known ? typed.view : predicted);
      end
    end
  end

  initial begin
    logic [SIZE_W-1:0] size_plan [9];
    lean_t lean;
    int lean_left;
    int drain_wait;
    size_plan = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd2, 5'd16, 5'd16, 5'd16};
    size_plan[6] = SIZE_W'($urandom_range(1, 16));
    size_plan[7] = SIZE_W'($urandom_range(0, 31));
    lean = LEAN_FILL;
    lean_left = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct = 12;
    receiver_idle_pct = 68;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_SIZE)
        write_size(directed_rows[i].value[SIZE_W-1:0]);
      else
        send_word(directed_rows[i].op, directed_rows[i].value,
                  directed_rows[i].known, directed_rows[i].view);
    end

    // random part: three idling phases, three sizes each
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 12 : ((phase == 1) ? 68 : 0);
      receiver_idle_pct = (phase == 0) ? 68 : ((phase == 1) ? 12 : 0);
      for (int sub = 0; sub < 3; sub++) begin
        write_size(size_plan[phase * 3 + sub]);
        if (phase == 2 && sub == 1) hold_requests++;
        for (int n = 0; n < WORDS_PER_SIZE; n++) begin
          if (lean_left == 0) begin
            lean = lean_t'($urandom_range(2));
            lean_left = $urandom_range(8, 24);
          end
          lean_left--;
          send_word(pick_op(lean), pick_word(), 1'b0, '0);
        end
      end
    end

    in_valid <= 1'b0;
    drain_wait = 0;
    do begin
      @(posedge clk);
      drain_wait++;
    end while (expected_views.size() != 0 && drain_wait < 5000);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_views.size() != 0)
      report_mismatch("results never delivered", expected_views.size(), 0);

    if (mismatch_count == 0) begin
      $display("bounded_ring_deque_top verification clean");
    end else begin
      $display("bounded_ring_deque_top verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #3_600_000;
    $display("bounded_ring_deque_top verification failed");
    $finish;
  end

endmodule
